// File: sv/multi_stack_min_tracker_core_assert.svh
// Assertion macros shared by the checker of the multi stack minimum tracker.
`ifndef MULTI_STACK_MIN_TRACKER_CORE_ASSERT_SVH
`define MULTI_STACK_MIN_TRACKER_CORE_ASSERT_SVH

// Check that cons holds in the same cycle as ante.
`define MSTK_ASSERT_NOW(name, clk, rstn, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("mstk assertion failed");

// Check that cons holds in the cycle after ante.
`define MSTK_ASSERT_NEXT(name, clk, rstn, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("mstk assertion failed");

`endif

// File: sv/mstk_pkg.sv
// Shared types and constants of the multi stack minimum tracker.
package mstk_pkg;

  // Fixed field widths
  localparam int PRIO_W     = 8;
  localparam int IDX_W      = 4;
  localparam int MODE_W     = 3;
  localparam int STATUS_W   = 2;
  localparam int OSTACK_W   = 4;
  localparam int OTIER_W    = 5;
  localparam int OBLK_W     = 9;
  localparam int CFG_SIU_W  = 5;
  localparam int CFG_ADDR_W = 1;
  localparam int CFG_DATA_W = 8;
  localparam int S_TDATA_W  = 16;
  localparam int M_TDATA_W  = 32;

  // Configuration register indexes
  localparam logic [CFG_ADDR_W-1:0] CFG_STACKS_IN_USE = 1'b0;
  localparam logic [CFG_ADDR_W-1:0] CFG_EMPTY_MIN     = 1'b1;

  typedef enum logic [MODE_W-1:0] {
    MODE_LOAD     = 3'd0,
    MODE_SET      = 3'd1,
    MODE_REMOVE   = 3'd2,
    MODE_RETRIEVE = 3'd3,
    MODE_RELOCATE = 3'd4
  } mode_e;

  typedef enum logic [STATUS_W-1:0] {
    STAT_DONE    = 2'd0,
    STAT_REFUSED = 2'd1,
    STAT_BAD     = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_HDR,
    ST_SCAN,
    ST_SLOT,
    ST_DEST,
    ST_SRC,
    ST_OUT
  } state_e;

endpackage

// File: sv/multi_stack_min_tracker_core.sv
// From the idle state, unused modes go straight to the output state; load, refused steps and a
// retrieve that empties its stack or finds it empty pass the header state first; remove and
// other retrieves pass header and slot states; relocate passes header, destination and source
// states, stopping after destination if it is bad; set target scans the headers in turn.
// One item is in work at a time; the input is ready again once the result is loaded.
// Reset clears the control state and every header valid bit at once; slots are written first.
module multi_stack_min_tracker_core #(
  parameter int MAX_STACKS = 16,
  parameter int MAX_TIERS  = 16,
  parameter int MAX_BLOCKS = 255
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // stack_index[3:0], value[11:4], zero pad
  input  logic [mstk_pkg::S_TDATA_W-1:0]    s_axis_tdata,
  // mode[2:0]
  input  logic [mstk_pkg::MODE_W-1:0]       s_axis_tuser,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // moved_priority[7:0], target_found[8], target_stack[12:9], target_tier[17:13],
  // blocks_left[26:18], zero pad
  output logic [mstk_pkg::M_TDATA_W-1:0]    m_axis_tdata,
  // status[1:0]
  output logic [mstk_pkg::STATUS_W-1:0]     m_axis_tuser,
  input  logic                              cfg_we_i,
  input  logic [mstk_pkg::CFG_ADDR_W-1:0]   cfg_addr_i,
  input  logic [mstk_pkg::CFG_DATA_W-1:0]   cfg_wdata_i
);
  import mstk_pkg::*;

  localparam int STACK_W    = (MAX_STACKS > 1) ? $clog2(MAX_STACKS) : 1;
  localparam int CNT_W      = $clog2(MAX_STACKS + 1);
  localparam int LIVE_W     = (CNT_W > CFG_SIU_W) ? CNT_W : CFG_SIU_W;
  localparam int HGT_W      = $clog2(MAX_TIERS + 1);
  localparam int ABV_W      = $clog2(MAX_TIERS + 1);
  localparam int SLOT_DEPTH = MAX_STACKS * MAX_TIERS;
  localparam int SLOT_AW    = $clog2(SLOT_DEPTH);
  localparam int BLK_W      = $clog2(MAX_BLOCKS + 1);
  localparam int PAD_W      = M_TDATA_W - PRIO_W - 1 - OSTACK_W - OTIER_W - OBLK_W;

  typedef struct packed {
    logic [PRIO_W-1:0] minv;
    logic [ABV_W-1:0]  above;
    logic [HGT_W-1:0]  height;
  } hdr_t;

  typedef struct packed {
    logic [PRIO_W-1:0] prio;
    logic [PRIO_W-1:0] minv;
    logic [ABV_W-1:0]  above;
  } slot_t;

  function automatic logic [SLOT_AW-1:0] slot_addr(logic [STACK_W-1:0] s,
                                                   logic [HGT_W-1:0] t);
    return SLOT_AW'(s * MAX_TIERS + t);
  endfunction

  // Control and payload registers
  state_e               state_q, state_d;
  mode_e                mode_q, mode_d;
  logic [IDX_W-1:0]     idx_q, idx_d;
  logic [PRIO_W-1:0]    val_q, val_d;
  logic [CFG_SIU_W-1:0] siu_q, siu_d;
  logic [PRIO_W-1:0]    emin_q, emin_d;
  logic [PRIO_W-1:0]    tprio_q, tprio_d;
  logic                 tvalid_q, tvalid_d;
  logic [STACK_W-1:0]   tstack_q, tstack_d;
  logic [OTIER_W-1:0]   ttier_q, ttier_d;
  logic [BLK_W-1:0]     blk_q, blk_d;
  logic [STACK_W-1:0]   chk_q, chk_d;
  hdr_t                 th_q, th_d;
  status_e              res_status_q, res_status_d;
  logic [PRIO_W-1:0]    res_moved_q, res_moved_d;
  logic                 m_valid_q, m_valid_d;
  logic [M_TDATA_W-1:0] m_data_q, m_data_d;
  logic [STATUS_W-1:0]  m_user_q, m_user_d;

  // Memories and their ports
  hdr_t                 hdr_mem_q [MAX_STACKS];
  logic [MAX_STACKS-1:0] hdr_vld_q;
  hdr_t                 hdr_rd_q;
  logic                 hdr_rd_vld_q;
  slot_t                slot_mem_q [SLOT_DEPTH];
  slot_t                slot_rd_q;

  logic                 hdr_re, hdr_we, slot_re, slot_we;
  logic [STACK_W-1:0]   hdr_raddr, hdr_waddr;
  hdr_t                 hdr_wdata;
  logic [SLOT_AW-1:0]   slot_raddr, slot_waddr;
  slot_t                slot_wdata;

  // Derived views
  logic [LIVE_W-1:0]    live;
  logic [LIVE_W-1:0]    idx_ext, ts_ext, chk_ext;
  logic [STACK_W-1:0]   idx_s;
  hdr_t                 hdr_eff;
  logic [PRIO_W-1:0]    hdr_min;
  logic                 hdr_full;

  assign live = (LIVE_W'(siu_q) < LIVE_W'(MAX_STACKS)) ? LIVE_W'(siu_q) : LIVE_W'(MAX_STACKS);
  assign idx_ext = LIVE_W'(idx_q);
  assign ts_ext  = LIVE_W'(tstack_q);
  assign chk_ext = LIVE_W'(chk_q);
  assign idx_s   = STACK_W'(idx_q);

  // Unwritten headers read as an empty stack
  always_comb begin
    if (hdr_rd_vld_q) begin
      hdr_eff = hdr_rd_q;
    end else begin
      hdr_eff.minv   = emin_q;
      hdr_eff.above  = '0;
      hdr_eff.height = '0;
    end
  end

  assign hdr_min  = (hdr_eff.height == '0) ? emin_q : hdr_eff.minv;
  assign hdr_full = hdr_eff.height >= HGT_W'(MAX_TIERS);

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_user_q;

  // Next state, memory requests and result
  always_comb begin
    hdr_t  nh;
    slot_t ns;

    state_d      = state_q;
    mode_d       = mode_q;
    idx_d        = idx_q;
    val_d        = val_q;
    siu_d        = siu_q;
    emin_d       = emin_q;
    tprio_d      = tprio_q;
    tvalid_d     = tvalid_q;
    tstack_d     = tstack_q;
    ttier_d      = ttier_q;
    blk_d        = blk_q;
    chk_d        = chk_q;
    th_d         = th_q;
    res_status_d = res_status_q;
    res_moved_d  = res_moved_q;
    m_valid_d    = m_valid_q;
    m_data_d     = m_data_q;
    m_user_d     = m_user_q;

    hdr_re     = 1'b0;
    hdr_raddr  = tstack_q;
    hdr_we     = 1'b0;
    hdr_waddr  = tstack_q;
    hdr_wdata  = hdr_eff;
    slot_re    = 1'b0;
    slot_raddr = '0;
    slot_we    = 1'b0;
    slot_waddr = '0;
    slot_wdata = slot_rd_q;
    nh         = hdr_eff;
    ns         = slot_rd_q;

    // Drop the output item once taken
    if (m_valid_q && m_axis_tready) begin
      m_valid_d = 1'b0;
    end

    // Configuration writes
    if (cfg_we_i) begin
      if (cfg_addr_i == CFG_STACKS_IN_USE) begin
        siu_d = cfg_wdata_i[CFG_SIU_W-1:0];
      end
      if (cfg_addr_i == CFG_EMPTY_MIN) begin
        emin_d = cfg_wdata_i[PRIO_W-1:0];
      end
    end

    case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          mode_d       = mode_e'(s_axis_tuser);
          idx_d        = s_axis_tdata[IDX_W-1:0];
          val_d        = s_axis_tdata[IDX_W +: PRIO_W];
          res_status_d = STAT_DONE;
          res_moved_d  = '0;
          case (mode_e'(s_axis_tuser))
            MODE_LOAD: begin
              hdr_re    = 1'b1;
              hdr_raddr = STACK_W'(s_axis_tdata[IDX_W-1:0]);
              state_d   = ST_HDR;
            end
            MODE_SET: begin
              // Start the header scan and drop the old target
              hdr_re    = 1'b1;
              hdr_raddr = '0;
              chk_d     = '0;
              tprio_d   = s_axis_tdata[IDX_W +: PRIO_W];
              tvalid_d  = 1'b0;
              tstack_d  = '0;
              ttier_d   = '1;
              state_d   = ST_SCAN;
            end
            MODE_REMOVE, MODE_RETRIEVE, MODE_RELOCATE: begin
              hdr_re    = 1'b1;
              hdr_raddr = tstack_q;
              state_d   = ST_HDR;
            end
            default: begin
              res_status_d = STAT_BAD;
              state_d      = ST_OUT;
            end
          endcase
        end
      end

      ST_HDR: begin
        state_d = ST_OUT;
        case (mode_q)
          MODE_LOAD: begin
            if (idx_ext >= live || hdr_full || blk_q >= BLK_W'(MAX_BLOCKS)) begin
              res_status_d = STAT_BAD;
            end else begin
              if (val_q < hdr_min) begin
                nh.minv  = val_q;
                nh.above = '0;
              end else begin
                nh.minv  = hdr_min;
                nh.above = hdr_eff.above + ABV_W'(1);
              end
              nh.height  = hdr_eff.height + HGT_W'(1);
              ns.prio    = val_q;
              ns.minv    = nh.minv;
              ns.above   = nh.above;
              slot_we    = 1'b1;
              slot_waddr = slot_addr(idx_s, hdr_eff.height);
              slot_wdata = ns;
              hdr_we     = 1'b1;
              hdr_waddr  = idx_s;
              hdr_wdata  = nh;
              blk_d      = blk_q + BLK_W'(1);
              // Refresh the target when loading onto its stack
              if (tvalid_q && idx_ext == ts_ext) begin
                if (nh.minv == tprio_q) begin
                  ttier_d = OTIER_W'(hdr_eff.height) - OTIER_W'(nh.above);
                end else begin
                  tvalid_d = 1'b0;
                  tstack_d = '0;
                  ttier_d  = '1;
                end
              end
            end
          end
          MODE_REMOVE: begin
            if (!tvalid_q || hdr_eff.above == '0) begin
              res_status_d = STAT_REFUSED;
            end else begin
              slot_re    = 1'b1;
              slot_raddr = slot_addr(tstack_q, hdr_eff.height - HGT_W'(1));
              nh.above   = hdr_eff.above - ABV_W'(1);
              nh.height  = hdr_eff.height - HGT_W'(1);
              hdr_we     = 1'b1;
              hdr_waddr  = tstack_q;
              hdr_wdata  = nh;
              if (blk_q != '0) begin
                blk_d = blk_q - BLK_W'(1);
              end
              state_d = ST_SLOT;
            end
          end
          MODE_RETRIEVE: begin
            if (!tvalid_q || hdr_eff.above != '0) begin
              res_status_d = STAT_REFUSED;
            end else if (hdr_eff.height == '0) begin
              res_status_d = STAT_BAD;
            end else begin
              res_moved_d = tprio_q;
              tvalid_d    = 1'b0;
              tstack_d    = '0;
              ttier_d     = '1;
              if (blk_q != '0) begin
                blk_d = blk_q - BLK_W'(1);
              end
              if (hdr_eff.height > HGT_W'(1)) begin
                // Restore minimum and count from the new top slot; hold the stack index
                th_d       = hdr_eff;
                chk_d      = tstack_q;
                slot_re    = 1'b1;
                slot_raddr = slot_addr(tstack_q, hdr_eff.height - HGT_W'(2));
                state_d    = ST_SLOT;
              end else begin
                nh.minv   = emin_q;
                nh.above  = '0;
                nh.height = '0;
                hdr_we    = 1'b1;
                hdr_waddr = tstack_q;
                hdr_wdata = nh;
              end
            end
          end
          MODE_RELOCATE: begin
            if (!tvalid_q || hdr_eff.above == '0) begin
              res_status_d = STAT_REFUSED;
            end else begin
              th_d       = hdr_eff;
              hdr_re     = 1'b1;
              hdr_raddr  = idx_s;
              slot_re    = 1'b1;
              slot_raddr = slot_addr(tstack_q, hdr_eff.height - HGT_W'(1));
              state_d    = ST_DEST;
            end
          end
          default: begin
            res_status_d = STAT_BAD;
          end
        endcase
      end

      ST_SCAN: begin
        // Compare the header read last cycle, fetch the next one
        if (chk_ext < live && hdr_min == val_q) begin
          tvalid_d = 1'b1;
          tstack_d = chk_q;
          ttier_d  = OTIER_W'(hdr_eff.height) - OTIER_W'(hdr_eff.above) - OTIER_W'(1);
          state_d  = ST_OUT;
        end else if (chk_ext + LIVE_W'(1) >= live) begin
          state_d = ST_OUT;
        end else begin
          hdr_re    = 1'b1;
          hdr_raddr = chk_q + STACK_W'(1);
          chk_d     = chk_q + STACK_W'(1);
        end
      end

      ST_SLOT: begin
        state_d = ST_OUT;
        case (mode_q)
          MODE_REMOVE: begin
            res_moved_d = slot_rd_q.prio;
          end
          MODE_RETRIEVE: begin
            nh.minv   = slot_rd_q.minv;
            nh.above  = slot_rd_q.above;
            nh.height = th_q.height - HGT_W'(1);
            hdr_we    = 1'b1;
            hdr_waddr = chk_q;
            hdr_wdata = nh;
          end
          default: begin
          end
        endcase
      end

      ST_DEST: begin
        if (idx_ext >= live || idx_ext == ts_ext || hdr_full) begin
          res_status_d = STAT_BAD;
          state_d      = ST_OUT;
        end else begin
          ns.prio = slot_rd_q.prio;
          if (slot_rd_q.prio < hdr_min) begin
            ns.minv  = slot_rd_q.prio;
            ns.above = '0;
          end else begin
            ns.minv  = hdr_min;
            ns.above = hdr_eff.above + ABV_W'(1);
          end
          nh.minv     = ns.minv;
          nh.above    = ns.above;
          nh.height   = hdr_eff.height + HGT_W'(1);
          slot_we     = 1'b1;
          slot_waddr  = slot_addr(idx_s, hdr_eff.height);
          slot_wdata  = ns;
          hdr_we      = 1'b1;
          hdr_waddr   = idx_s;
          hdr_wdata   = nh;
          res_moved_d = slot_rd_q.prio;
          state_d     = ST_SRC;
        end
      end

      ST_SRC: begin
        // Pop the moved block off the target stack
        nh.minv   = th_q.minv;
        nh.above  = th_q.above - ABV_W'(1);
        nh.height = th_q.height - HGT_W'(1);
        hdr_we    = 1'b1;
        hdr_waddr = tstack_q;
        hdr_wdata = nh;
        state_d   = ST_OUT;
      end

      ST_OUT: begin
        if (!m_valid_q || m_axis_tready) begin
          m_valid_d = 1'b1;
          m_data_d  = {{PAD_W{1'b0}}, OBLK_W'(blk_q), ttier_q, OSTACK_W'(tstack_q),
                       tvalid_q, res_moved_q};
          m_user_d  = res_status_q;
          state_d   = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      siu_q     <= CFG_SIU_W'(16);
      emin_q    <= '1;
      tprio_q   <= '0;
      tvalid_q  <= 1'b0;
      tstack_q  <= '0;
      ttier_q   <= '1;
      blk_q     <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      siu_q     <= siu_d;
      emin_q    <= emin_d;
      tprio_q   <= tprio_d;
      tvalid_q  <= tvalid_d;
      tstack_q  <= tstack_d;
      ttier_q   <= ttier_d;
      blk_q     <= blk_d;
      m_valid_q <= m_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    mode_q       <= mode_d;
    idx_q        <= idx_d;
    val_q        <= val_d;
    chk_q        <= chk_d;
    th_q         <= th_d;
    res_status_q <= res_status_d;
    res_moved_q  <= res_moved_d;
    m_data_q     <= m_data_d;
    m_user_q     <= m_user_d;
  end

  // Header memory with registered read
  always_ff @(posedge clk_i) begin
    if (hdr_we) begin
      hdr_mem_q[hdr_waddr] <= hdr_wdata;
    end
    if (hdr_re) begin
      hdr_rd_q <= hdr_mem_q[hdr_raddr];
    end
  end

  // Header valid bits, cleared at reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hdr_vld_q    <= '0;
      hdr_rd_vld_q <= 1'b0;
    end else begin
      if (hdr_we) begin
        hdr_vld_q[hdr_waddr] <= 1'b1;
      end
      if (hdr_re) begin
        hdr_rd_vld_q <= hdr_vld_q[hdr_raddr];
      end
    end
  end

  // Slot memory with registered read
  always_ff @(posedge clk_i) begin
    if (slot_we) begin
      slot_mem_q[slot_waddr] <= slot_wdata;
    end
    if (slot_re) begin
      slot_rd_q <= slot_mem_q[slot_raddr];
    end
  end

endmodule

// File: sv/mstk_checker.sv
// Port-level checker of the multi stack minimum tracker, bound to its core module.
`include "multi_stack_min_tracker_core_assert.svh"

module mstk_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready,
  input logic [mstk_pkg::M_TDATA_W-1:0]  m_axis_tdata,
  input logic [mstk_pkg::STATUS_W-1:0]   m_axis_tuser
);
  import mstk_pkg::*;

  // Hold a stalled output item
  `MSTK_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))

  // A refused or bad step moves no block
  `MSTK_ASSERT_NOW(a_refused_no_move, clk_i, rst_ni, m_axis_tvalid && (m_axis_tuser != STAT_DONE), m_axis_tdata[7:0] == 8'd0)

  // Without a target, stack and tier show their dropped values
  `MSTK_ASSERT_NOW(a_no_target_fields, clk_i, rst_ni, m_axis_tvalid && !m_axis_tdata[8], (m_axis_tdata[12:9] == 4'd0) && (m_axis_tdata[17:13] == 5'h1f))

endmodule

bind multi_stack_min_tracker_core mstk_checker u_mstk_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
